### rtl/core/acescc_pkg.sv
// Shared constants and table builders for the ACEScc transfer block.
package acescc_pkg;

  localparam int FRAC_BITS_DEF  = 24;
  localparam int TABLE_BITS_DEF = 8;
  localparam int ARITH_FRAC     = 30;
  localparam int DATA_W         = 42;
  localparam int MAXLIN_W       = 41;
  localparam int TAB_W          = 32;
  localparam int LOG_W          = 40;
  localparam int FRAC_W         = 30;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR = 1'b1;

  function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] b;
    a = a_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > a) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (a >= r + b) begin
          a = a - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic logic [TAB_W-1:0] log_entry(input int i, input int tb);
    logic [63:0] v;
    logic [63:0] r;
    if (i >= (1 << tb)) return TAB_W'(64'd1 << ARITH_FRAC);
    v = (64'd1 << ARITH_FRAC) + (64'(i) << (ARITH_FRAC - tb));
    r = 64'd0;
    for (int k = 0; k < ARITH_FRAC; k++) begin
      v = (v * v) >> ARITH_FRAC;
      r = r << 1;
      if (v >= (64'd2 << ARITH_FRAC)) begin
        r = r | 64'd1;
        v = v >> 1;
      end
    end
    return TAB_W'(r);
  endfunction

  function automatic logic [TAB_W-1:0] exp_entry(input int i, input int tb);
    logic [63:0] roots [0:12];
    logic [63:0] p;
    if (i >= (1 << tb)) return TAB_W'(64'd2 << ARITH_FRAC);
    roots[0] = 64'd2 << ARITH_FRAC;
    for (int k = 1; k <= 12; k++) begin
      roots[k] = isqrt64(roots[k-1] << ARITH_FRAC);
    end
    p = 64'd1 << ARITH_FRAC;
    for (int k = 0; k < tb; k++) begin
      if (((i >> k) & 1) != 0) p = (p * roots[tb-k]) >> ARITH_FRAC;
    end
    return TAB_W'(p);
  endfunction

endpackage

### rtl/core/acescc_in_if.sv
// Input channel carrying one sample per item.
interface acescc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [acescc_pkg::DATA_W-1:0] sample;
  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

### rtl/core/acescc_out_if.sv
// Output channel carrying one converted value and its clip flag per item.
interface acescc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [acescc_pkg::DATA_W-1:0] converted;
  logic                               clipped;
  modport source(output valid, output converted, output clipped, input ready);
  modport sink(input valid, input converted, input clipped, output ready);
endinterface

### rtl/core/acescc_interp.sv
// Three-stage table lookup with linear interpolation for log2 or exp2.
module acescc_interp #(
  parameter int TABLE_BITS = acescc_pkg::TABLE_BITS_DEF,
  parameter bit IS_EXP     = 1'b0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [acescc_pkg::FRAC_W-1:0]  frac,
  output logic [acescc_pkg::TAB_W-1:0]   result
);
  import acescc_pkg::*;

  localparam int TAB_N     = (1 << TABLE_BITS) + 1;
  localparam int IDX_SHIFT = FRAC_W - TABLE_BITS;

  typedef logic [TAB_W-1:0] tab_arr_t [0:TAB_N-1];

  function automatic tab_arr_t build_tab();
    tab_arr_t t;
    for (int i = 0; i < TAB_N; i++) begin
      t[i] = IS_EXP ? exp_entry(i, TABLE_BITS) : log_entry(i, TABLE_BITS);
    end
    return t;
  endfunction

  localparam tab_arr_t TAB = build_tab();

  logic [TABLE_BITS-1:0]       idx;
  logic [TABLE_BITS:0]         idx_hi;
  logic [TAB_W-1:0]            lo1;
  logic [TAB_W-1:0]            d1;
  logic [IDX_SHIFT-1:0]        rem1;
  logic [TAB_W-1:0]            lo2;
  logic [TAB_W+IDX_SHIFT-1:0]  prod2;

  assign idx    = frac[FRAC_W-1:IDX_SHIFT];
  assign idx_hi = {1'b0, idx} + {{TABLE_BITS{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (en) begin
      lo1    <= TAB[idx];
      d1     <= TAB[idx_hi] - TAB[idx];
      rem1   <= frac[IDX_SHIFT-1:0];
      lo2    <= lo1;
      prod2  <= d1 * rem1;
      result <= lo2 + prod2[IDX_SHIFT +: TAB_W];
    end
  end

endmodule

### rtl/core/acescc_log2.sv
// Pipelined log2 of a positive fixed-point value, result in Q.30, six stages.
module acescc_log2 #(
  parameter int FRAC_BITS  = acescc_pkg::FRAC_BITS_DEF,
  parameter int TABLE_BITS = acescc_pkg::TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [acescc_pkg::DATA_W-1:0]       value,
  output logic signed [acescc_pkg::LOG_W-1:0] log_out
);
  import acescc_pkg::*;

  logic [5:0]        e_c;
  logic [5:0]        e1;
  logic [DATA_W-1:0] v1;
  logic [DATA_W-1:0] w_c;
  logic [FRAC_W-1:0] frac2;
  logic [5:0]        e_d [2:5];
  logic [TAB_W-1:0]  mant;

  always_comb begin
    e_c = 6'd0;
    for (int i = 0; i < DATA_W; i++) begin
      if (value[i]) e_c = 6'(i);
    end
  end

  assign w_c = v1 << (6'(DATA_W - 1) - e1);

  always_ff @(posedge clk) begin
    if (en) begin
      e1     <= e_c;
      v1     <= value;
      frac2  <= w_c[DATA_W-2 -: FRAC_W];
      e_d[2] <= e1;
      for (int k = 3; k <= 5; k++) e_d[k] <= e_d[k-1];
      log_out <= ((LOG_W'(e_d[5]) - LOG_W'(FRAC_BITS)) <<< ARITH_FRAC) + LOG_W'(mant);
    end
  end

  acescc_interp #(.TABLE_BITS(TABLE_BITS), .IS_EXP(1'b0)) u_interp (
    .clk(clk), .en(en), .frac(frac2), .result(mant)
  );

endmodule

### rtl/core/acescc_exp2.sv
// Pipelined exp2 of a Q.30 value to saturated fixed point, five stages.
module acescc_exp2 #(
  parameter int FRAC_BITS  = acescc_pkg::FRAC_BITS_DEF,
  parameter int TABLE_BITS = acescc_pkg::TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [acescc_pkg::LOG_W-1:0] arg,
  output logic [acescc_pkg::DATA_W-1:0]       result
);
  import acescc_pkg::*;

  localparam int N_W = LOG_W - ARITH_FRAC;
  localparam logic [DATA_W-1:0] POS_SAT = {1'b0, {(DATA_W-1){1'b1}}};

  logic [FRAC_W-1:0]     f1;
  logic signed [N_W-1:0] n_d [1:4];
  logic [TAB_W-1:0]      mant;
  logic signed [10:0]    sh;
  logic signed [10:0]    rsh;
  logic [DATA_W-1:0]     mext;
  logic [DATA_W-1:0]     rl;
  logic [DATA_W-1:0]     rr;
  logic [DATA_W-1:0]     r_c;

  always_comb begin
    sh   = 11'(n_d[4]) + 11'(FRAC_BITS - ARITH_FRAC);
    rsh  = -sh;
    mext = DATA_W'(mant);
    rl   = mext << sh[3:0];
    rr   = (mext + (DATA_W'(1) << (rsh[5:0] - 6'd1))) >> rsh[5:0];
    if (sh > 11'sd10) begin
      r_c = POS_SAT;
    end else if (sh >= 11'sd0) begin
      r_c = rl[DATA_W-1] ? POS_SAT : rl;
    end else if (rsh > 11'sd40) begin
      r_c = '0;
    end else begin
      r_c = rr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1     <= arg[FRAC_W-1:0];
      n_d[1] <= arg[LOG_W-1:ARITH_FRAC];
      for (int k = 2; k <= 4; k++) n_d[k] <= n_d[k-1];
      result <= r_c;
    end
  end

  acescc_interp #(.TABLE_BITS(TABLE_BITS), .IS_EXP(1'b1)) u_interp (
    .clk(clk), .en(en), .frac(f1), .result(mant)
  );

endmodule

### rtl/core/acescc_log_encode_decode_top.sv
// Top level of the ACEScc encode and decode pipeline.
//
// Channels: in_ch takes one signed Q17.24 sample per item, out_ch gives the
// converted value and a clip flag per item. Both use valid and ready, and an
// item moves on a rising edge where both are high.
// The cfg port writes register 0 (inverse) and register 1 (max_linear); the
// user must write them only while the block is idle, which the block itself
// does not enforce. Inverse 0 encodes linear to ACEScc, 1 decodes.
// An item passes the ten register stages of input scaling, log2 unit, exp2
// unit and the final scaling multiply. Throughput is one item per cycle while
// the output is not stalled, as every stage then takes a new item each cycle.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_ch.ready drops in the same cycle, so no item is lost or repeated.
// Bubbles advance freely while the output register is empty.
// Reset clears all valid bits and loads the register defaults: encode mode
// and a maximum linear value of 65504.
module acescc_log_encode_decode_top #(
  parameter int FRAC_BITS  = acescc_pkg::FRAC_BITS_DEF,
  parameter int TABLE_BITS = acescc_pkg::TABLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  acescc_in_if.sink                          in_ch,
  acescc_out_if.source                       out_ch,
  input  logic                               cfg_wen,
  input  logic [acescc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [acescc_pkg::MAXLIN_W-1:0]    cfg_data
);
  import acescc_pkg::*;

  localparam logic [MAXLIN_W-1:0] MAXLIN_RESET = MAXLIN_W'(64'd65504 << FRAC_BITS);
  localparam logic [DATA_W-1:0] TINY = DATA_W'(1) << (FRAC_BITS - 15);
  localparam logic signed [DATA_W-1:0] LIM4 = DATA_W'(4) << FRAC_BITS;
  localparam logic signed [LOG_W-1:0] ONE_Q = LOG_W'(1) << ARITH_FRAC;
  localparam logic signed [LOG_W-1:0] OFFSET_Q = 40'sd10436770529;
  localparam logic signed [LOG_W-1:0] LIM15 = 40'sd16106127360;
  localparam logic signed [LOG_W-1:0] NEG16 = -40'sd17179869184;
  localparam logic [30:0] SCALE_Q26 = 31'd1175747297;
  localparam logic [25:0] RECIP_Q30 = 26'd61286634;
  localparam int SH_OUT = 2 * ARITH_FRAC - FRAC_BITS;

  logic                  inverse;
  logic [MAXLIN_W-1:0]   max_linear;
  logic [10:1]           vld;
  logic                  en;

  logic signed [DATA_W-1:0] s;
  logic                     s_sub;
  logic [DATA_W-1:0]        v_c;
  logic signed [DATA_W-1:0] sc;
  logic [DATA_W-1:0]        sa;
  logic [63:0]              xw;
  logic [32:0]              xa;

  logic [7:1]               negd;
  logic [7:1]               subd;
  logic                     dneg1;
  logic [63:0]              prod1;
  logic [DATA_W-1:0]        v1;

  logic [63:0]              mr_c;
  logic signed [LOG_W-1:0]  t_c;
  logic signed [LOG_W-1:0]  t_d [2:7];
  logic                     ba_c;
  logic                     ba_d [3:7];
  logic signed [LOG_W-1:0]  u_c;

  logic signed [LOG_W-1:0]  logv7;
  logic [DATA_W-1:0]        r7;

  logic signed [LOG_W-1:0]  lv_c;
  logic signed [LOG_W-1:0]  lv8;
  logic signed [DATA_W-1:0] dy_c;
  logic                     dclip_c;
  logic signed [DATA_W-1:0] dy8;
  logic                     dclip8;

  logic [LOG_W-1:0]         labs;
  logic                     lneg9;
  logic [43:0]              pp_hi9;
  logic [43:0]              pp_lo9;
  logic signed [DATA_W-1:0] dy9;
  logic                     dclip9;

  logic [63:0]              p_c;
  logic [DATA_W-1:0]        q_c;
  logic signed [DATA_W-1:0] ey_c;

  assign en          = !vld[10] || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld[10];

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse    <= 1'b0;
      max_linear <= MAXLIN_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_INVERSE:    inverse    <= cfg_data[0];
        CFG_MAX_LINEAR: max_linear <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:1], in_ch.valid};
    end
  end

  always_comb begin
    s     = in_ch.sample;
    s_sub = !s[DATA_W-1] && ($unsigned(s) < TINY);
    if (inverse) begin
      v_c = DATA_W'(max_linear);
    end else if (s[DATA_W-1]) begin
      v_c = TINY;
    end else if (s_sub) begin
      v_c = TINY + $unsigned(s);
    end else begin
      v_c = $unsigned(s);
    end
    if (s > LIM4) sc = LIM4;
    else if (s < -LIM4) sc = -LIM4;
    else sc = s;
    sa = sc[DATA_W-1] ? $unsigned(-sc) : $unsigned(sc);
    xw = 64'(sa) << (ARITH_FRAC - FRAC_BITS);
    xa = xw[32:0];
  end

  always_comb begin
    mr_c = (prod1 + (64'd1 << 25)) >> 26;
    t_c  = (dneg1 ? -$signed(LOG_W'(mr_c)) : $signed(LOG_W'(mr_c))) - OFFSET_Q;
    ba_c = t_d[2] <= LIM15;
    u_c  = ba_c ? t_d[2] + ONE_Q : t_d[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negd[1] <= s[DATA_W-1];
      subd[1] <= s_sub;
      for (int k = 2; k <= 7; k++) begin
        negd[k] <= negd[k-1];
        subd[k] <= subd[k-1];
      end
      dneg1  <= sc[DATA_W-1];
      prod1  <= xa * SCALE_Q26;
      v1     <= v_c;
      t_d[2] <= t_c;
      for (int k = 3; k <= 7; k++) t_d[k] <= t_d[k-1];
      ba_d[3] <= ba_c;
      for (int k = 4; k <= 7; k++) ba_d[k] <= ba_d[k-1];
    end
  end

  acescc_log2 #(.FRAC_BITS(FRAC_BITS), .TABLE_BITS(TABLE_BITS)) u_log2 (
    .clk(clk), .en(en), .value(v1), .log_out(logv7)
  );

  acescc_exp2 #(.FRAC_BITS(FRAC_BITS), .TABLE_BITS(TABLE_BITS)) u_exp2 (
    .clk(clk), .en(en), .arg(u_c), .result(r7)
  );

  always_comb begin
    if (negd[7]) lv_c = NEG16;
    else lv_c = logv7 - (subd[7] ? ONE_Q : '0);
    if (ba_d[7]) begin
      dy_c    = $signed(r7) - $signed(TINY);
      dclip_c = 1'b0;
    end else if ((max_linear != '0) && (t_d[7] <= logv7)) begin
      dy_c    = (r7 > DATA_W'(max_linear)) ? $signed(DATA_W'(max_linear)) : $signed(r7);
      dclip_c = 1'b0;
    end else begin
      dy_c    = $signed(DATA_W'(max_linear));
      dclip_c = 1'b1;
    end
  end

  assign labs = lv8[LOG_W-1] ? $unsigned(-lv8) : $unsigned(lv8);

  always_comb begin
    p_c  = {pp_hi9[43:0], 18'b0} + 64'(pp_lo9) + (64'd1 << (SH_OUT - 1));
    q_c  = DATA_W'(p_c >> SH_OUT);
    ey_c = lneg9 ? -$signed(q_c) : $signed(q_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lv8    <= lv_c + OFFSET_Q;
      dy8    <= dy_c;
      dclip8 <= dclip_c;
      lneg9  <= lv8[LOG_W-1];
      pp_hi9 <= labs[35:18] * RECIP_Q30;
      pp_lo9 <= labs[17:0] * RECIP_Q30;
      dy9    <= dy8;
      dclip9 <= dclip8;
      out_ch.converted <= inverse ? dy9 : ey_c;
      out_ch.clipped   <= inverse ? dclip9 : 1'b0;
    end
  end

endmodule

### rtl/core/acescc_checker.sv
// Port-level checker for the ACEScc block and its bind to the top level.
module acescc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [acescc_pkg::DATA_W-1:0] converted,
  input logic                             clipped
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready while output register is empty");

  a_clip_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> !converted[acescc_pkg::DATA_W-1])
    else $error("clipped item carries a negative value");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline is stalled");

endmodule

bind acescc_log_encode_decode_top acescc_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .converted(out_ch.converted),
  .clipped(out_ch.clipped)
);

### bench/acescc_log_encode_decode_top_test.sv
// Testbench for the ACEScc encode and decode block, checked against its own predictor.
`timescale 1ns / 1ps

module acescc_log_encode_decode_top_test;
  import acescc_pkg::*;

  localparam int ONE_SH = 30;
  localparam logic [63:0] MASK41 = (64'd1 << 41) - 1;
  localparam logic [63:0] MAXLIN_DEFAULT = 64'd65504 << 24;
  localparam longint OFFSET = 64'sd10436770529;
  localparam logic [63:0] RECIP = 64'd61286634;
  localparam logic [63:0] SCALE = 64'd1175747297;
  localparam int ERR_SHOWN = 10;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic signed [DATA_W-1:0] converted;
    logic clipped;
  } pixel_t;

  class transfer_scoreboard;
    logic [63:0] log_t [0:256];
    logic [63:0] exp_t [0:256];
    bit inverse;
    logic [63:0] max_lin;
    pixel_t pending [$];
    int errors;

    function new();
      logic [63:0] roots [0:8];
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] p;
      for (int i = 0; i < 256; i++) begin
        v = (64'd1 << ONE_SH) + (64'(i) << 22);
        r = 0;
        for (int k = 0; k < ONE_SH; k++) begin
          v = (v * v) >> ONE_SH;
          r = r << 1;
          if (v >= (64'd2 << ONE_SH)) begin
            r = r | 1;
            v = v >> 1;
          end
        end
        log_t[i] = r;
      end
      log_t[256] = 64'd1 << ONE_SH;
      roots[0] = 64'd2 << ONE_SH;
      for (int k = 1; k <= 8; k++) roots[k] = int_sqrt(roots[k-1] << ONE_SH);
      for (int i = 0; i < 256; i++) begin
        p = 64'd1 << ONE_SH;
        for (int k = 0; k < 8; k++)
          if ((i >> k) & 1) p = (p * roots[8-k]) >> ONE_SH;
        exp_t[i] = p;
      end
      exp_t[256] = 64'd2 << ONE_SH;
      inverse = 0;
      max_lin = MAXLIN_DEFAULT;
      errors = 0;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] a_in);
      logic [63:0] a;
      logic [63:0] r;
      logic [63:0] b;
      a = a_in;
      r = 0;
      b = 64'd1 << 62;
      while (b > a) b = b >> 2;
      while (b != 0) begin
        if (a >= r + b) begin
          a = a - (r + b);
          r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [63:0] lookup(bit use_exp, logic [63:0] frac);
      int idx;
      logic [63:0] rem;
      logic [63:0] lo;
      logic [63:0] hi;
      idx = int'((frac >> 22) & 255);
      rem = frac & ((64'd1 << 22) - 1);
      lo = use_exp ? exp_t[idx] : log_t[idx];
      hi = use_exp ? exp_t[idx+1] : log_t[idx+1];
      return lo + (((hi - lo) * rem) >> 22);
    endfunction

    function longint log2_fix(logic [63:0] v);
      int e;
      logic [63:0] m;
      e = 41;
      while (e > 0 && !v[e]) e--;
      m = (e >= ONE_SH) ? (v >> (e - ONE_SH)) : (v << (ONE_SH - e));
      m = m - (64'd1 << ONE_SH);
      return longint'(e - 24) * (64'sd1 << ONE_SH) + longint'(lookup(0, m));
    endfunction

    function longint exp2_fix(longint t);
      logic [63:0] f;
      longint n;
      logic [63:0] mant;
      logic [63:0] r;
      longint sh;
      f = t & ((64'd1 << ONE_SH) - 1);
      n = t >>> ONE_SH;
      mant = lookup(1, f);
      sh = n + 24 - ONE_SH;
      if (sh > 10) return longint'(MASK41);
      if (sh >= 0) begin
        r = mant << sh;
        return (r > MASK41) ? longint'(MASK41) : longint'(r);
      end
      if (-sh > 40) return 0;
      return longint'((mant + (64'd1 << (-sh - 1))) >> (-sh));
    endfunction

    function pixel_t convert(logic signed [DATA_W-1:0] sample);
      pixel_t res;
      longint s;
      longint lv;
      longint t;
      longint y;
      logic [63:0] m;
      bit neg;
      s = longint'(sample);
      res.clipped = 0;
      if (!inverse) begin
        if (s < 0) lv = -16 * (64'sd1 << ONE_SH);
        else if (s < 512) lv = log2_fix(64'(512 + s)) - (64'sd1 << ONE_SH);
        else lv = log2_fix(64'(s));
        lv = lv + OFFSET;
        neg = lv < 0;
        m = neg ? 64'(-lv) : 64'(lv);
        m = (m * RECIP + (64'd1 << 35)) >> 36;
        y = neg ? -longint'(m) : longint'(m);
      end else begin
        if (s > (64'sd4 << 24)) s = 64'sd4 << 24;
        if (s < -(64'sd4 << 24)) s = -(64'sd4 << 24);
        s = s * 64;
        neg = s < 0;
        m = neg ? 64'(-s) : 64'(s);
        m = (m * SCALE + (64'd1 << 25)) >> 26;
        t = (neg ? -longint'(m) : longint'(m)) - OFFSET;
        if (t <= 15 * (64'sd1 << ONE_SH)) begin
          y = exp2_fix(t + (64'sd1 << ONE_SH)) - 512;
        end else if (max_lin != 0 && t <= log2_fix(max_lin)) begin
          y = exp2_fix(t);
          if (y > longint'(max_lin)) y = longint'(max_lin);
        end else begin
          y = longint'(max_lin);
          res.clipped = 1;
        end
      end
      res.converted = y[DATA_W-1:0];
      return res;
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] sample);
      pending.push_back(convert(sample));
    endfunction

    function void check_pixel(logic signed [DATA_W-1:0] converted, logic clipped);
      pixel_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= ERR_SHOWN)
          $display("unexpected item: converted %0d clipped %0b", converted, clipped);
        return;
      end
      want = pending.pop_front();
      if (want.converted !== converted || want.clipped !== clipped) begin
        errors++;
        if (errors <= ERR_SHOWN)
          $display("mismatch: expected %0d/%0b got %0d/%0b",
                   want.converted, want.clipped, converted, clipped);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MAXLIN_W-1:0] cfg_data;
  acescc_in_if in_ch();
  acescc_out_if out_ch();

  acescc_log_encode_decode_top uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  transfer_scoreboard sb = new();
  bit no_idle;
  int stall_left;
  int cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 0;
      stall_left <= stall_left - 1;
    end else begin
      int g;
      g = pick_gap();
      out_ch.ready <= (g == 0);
      stall_left <= (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_pixel(out_ch.converted, out_ch.clipped);

  task automatic send_sample(logic signed [DATA_W-1:0] v);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.sample <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(v);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic set_mode(bit inv, logic [63:0] maxv);
    cfg_wen <= 1;
    cfg_index <= CFG_INVERSE;
    cfg_data <= MAXLIN_W'(inv);
    @(posedge clk);
    cfg_index <= CFG_MAX_LINEAR;
    cfg_data <= maxv[MAXLIN_W-1:0];
    @(posedge clk);
    cfg_wen <= 0;
    sb.inverse = inv;
    sb.max_lin = maxv & MASK41;
  endtask

  function logic signed [DATA_W-1:0] random_sample(bit inv);
    logic [63:0] w;
    int k;
    w = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    if (k == 0) return w[DATA_W-1:0];
    if (inv) begin
      w = w >> (37 + $urandom_range(0, 3));
      return (w[0] ? -1 : 1) * $signed({1'b0, w[40:0]});
    end
    if (k == 1) return -$signed({1'b0, w[40:0] >> $urandom_range(0, 40)});
    if (k == 2) return $signed(DATA_W'($urandom_range(0, 2000)));
    return $signed({1'b0, w[40:0] >> $urandom_range(0, 40)});
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_sample(random_sample(sb.inverse));
    end
    no_idle = 0;
  endtask

  logic signed [DATA_W-1:0] edge_vals [0:11];
  logic [63:0] modes_max [0:7];
  bit modes_inv [0:7];

  initial begin
    rst = 1;
    cfg_wen = 0;
    cfg_index = CFG_INVERSE;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.sample = 0;
    cycles = 0;
    no_idle = 0;
    edge_vals = '{-(42'sd1 <<< 41), (42'sd1 <<< 41) - 1, 0, 1, 511, 512, -1,
                  42'sd4 <<< 24, -(42'sd4 <<< 24), (42'sd4 <<< 24) + 1,
                  42'sd23672183, 42'sd1 <<< 24};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    drain();
    set_mode(1, MAXLIN_DEFAULT);
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    drain();
    modes_inv = '{0, 1, 1, 1, 1, 0, 1, 1};
    modes_max = '{MAXLIN_DEFAULT, MAXLIN_DEFAULT, 1, MASK41, 0,
                  {$urandom, $urandom}, {$urandom, $urandom},
                  64'($urandom) >> $urandom_range(0, 31)};
    foreach (modes_inv[i]) begin
      set_mode(modes_inv[i], modes_max[i]);
      run_random(128);
      drain();
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
